>>> rtl/multi_channel_timeout_timer_bank_assert.svh
// Assertion macros for the timeout timer bank
`ifndef MULTI_CHANNEL_TIMEOUT_TIMER_BANK_ASSERT_SVH
`define MULTI_CHANNEL_TIMEOUT_TIMER_BANK_ASSERT_SVH

`ifndef SYNTHESIS
`define MCTT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MCTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCTT_ASSERT(label, prop, msg)
`define MCTT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/mctt_pkg.sv
// Shared constants and types for the timeout timer bank
package mctt_pkg;

    localparam int NUM_TIMERS_DEF  = 7;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int REQ_W    = 3;
    localparam int ID_W     = 3;
    localparam int PERIOD_W = 16;
    localparam int MASK_W   = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_START = 3'd0,
        REQ_STOP  = 3'd1,
        REQ_TICK  = 3'd2,
        REQ_CHECK = 3'd3,
        REQ_CLEAR = 3'd4
    } req_kind_t;

endpackage

>>> rtl/mctt_if.sv
// Request and response channel interfaces for the timeout timer bank
interface mctt_req_if;
    import mctt_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ID_W-1:0]     timer_id;
    logic [PERIOD_W-1:0] period_ms;
    logic                has_handler;

    modport source (output valid, req_type, timer_id, period_ms, has_handler, input ready);
    modport sink   (input valid, req_type, timer_id, period_ms, has_handler, output ready);
endinterface

interface mctt_rsp_if;
    import mctt_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] expired_mask;
    logic [MASK_W-1:0] notify_mask;
    logic [MASK_W-1:0] running_mask;

    modport source (output valid, expired_mask, notify_mask, running_mask, input ready);
    modport sink   (input valid, expired_mask, notify_mask, running_mask, output ready);
endinterface

>>> rtl/multi_channel_timeout_timer_bank.sv
// Bank of one-shot timeout timers driven by a request stream
//
//   channel  direction  beat contents
//   req      in         req_type, timer_id, period_ms, has_handler
//   rsp      out        expired_mask, notify_mask, running_mask
//
// One request per cycle sustained while rsp is ready; each request yields one response beat.
// A request passes through the input register, then the response register.
// All timers update in parallel in the single stage between the two registers.
// Reset clears every timer and handler flag at once; no clearing pass.
// A stalled response holds the request register; req accepts again as rsp drains.
module multi_channel_timeout_timer_bank #(
    parameter int NUM_TIMERS  = mctt_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = mctt_pkg::COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    mctt_req_if.sink          req,
    mctt_rsp_if.source        rsp
);
    import mctt_pkg::*;

`include "multi_channel_timeout_timer_bank_assert.svh"

    logic                req_valid_reg, req_valid_next;
    logic [REQ_W-1:0]    req_type_reg;
    logic [ID_W-1:0]     timer_id_reg;
    logic [PERIOD_W-1:0] period_ms_reg;
    logic                has_handler_reg;

    logic [NUM_TIMERS-1:0]  armed_reg, armed_next;
    logic [NUM_TIMERS-1:0]  handler_reg, handler_next;
    logic [COUNT_WIDTH-1:0] count_reg [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] count_next [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] period_reg [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] period_next [NUM_TIMERS];

    logic                  out_valid_reg, out_valid_next;
    logic [NUM_TIMERS-1:0] expired_reg, expired_next;
    logic [NUM_TIMERS-1:0] notify_reg, notify_next;
    logic [NUM_TIMERS-1:0] running_reg;
    logic [NUM_TIMERS-1:0] sel;
    logic [NUM_TIMERS-1:0] over_period;
    logic                  proc;

    assign proc      = req_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || proc;
    assign rsp.valid = out_valid_reg;

    always_comb
    begin
        req_valid_next = req.ready ? req.valid : req_valid_reg;
        out_valid_next = proc ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            sel[i]         = (32'(timer_id_reg) == i);
            over_period[i] = armed_reg[i] && (count_reg[i] > period_reg[i]);
        end
    end

    always_comb
    begin
        armed_next   = armed_reg;
        handler_next = handler_reg;
        count_next   = count_reg;
        period_next  = period_reg;
        expired_next = '0;
        notify_next  = '0;
        if (proc)
        begin
            unique case (req_kind_t'(req_type_reg))
                REQ_START:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (sel[i] && !armed_reg[i])
                        begin
                            armed_next[i]   = 1'b1;
                            handler_next[i] = has_handler_reg;
                            count_next[i]   = '0;
                            period_next[i]  = COUNT_WIDTH'(period_ms_reg);
                        end
                    end
                end
                REQ_STOP:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (sel[i] && armed_reg[i])
                        begin
                            armed_next[i] = 1'b0;
                            count_next[i] = '0;
                        end
                    end
                end
                REQ_TICK:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (armed_reg[i] && (count_reg[i] < period_reg[i]))
                        begin
                            count_next[i] = count_reg[i] + COUNT_WIDTH'(1);
                        end
                    end
                end
                REQ_CHECK:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (armed_reg[i] && (count_reg[i] >= period_reg[i]))
                        begin
                            armed_next[i]   = 1'b0;
                            count_next[i]   = '0;
                            expired_next[i] = 1'b1;
                            notify_next[i]  = handler_reg[i];
                        end
                    end
                end
                REQ_CLEAR:
                begin
                    armed_next   = '0;
                    handler_next = '0;
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        count_next[i] = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            armed_reg     <= '0;
            handler_reg   <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            armed_reg     <= armed_next;
            handler_reg   <= handler_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg <= period_next;
        if (req.valid && req.ready)
        begin
            req_type_reg    <= req.req_type;
            timer_id_reg    <= req.timer_id;
            period_ms_reg   <= req.period_ms;
            has_handler_reg <= req.has_handler;
        end
        if (proc)
        begin
            expired_reg <= expired_next;
            notify_reg  <= notify_next;
            running_reg <= armed_next;
        end
    end

    for (genvar j = 0; j < MASK_W; j++)
    begin : g_mask
        if (j < NUM_TIMERS)
        begin : g_live
            assign rsp.expired_mask[j] = expired_reg[j];
            assign rsp.notify_mask[j]  = notify_reg[j];
            assign rsp.running_mask[j] = running_reg[j];
        end
        else
        begin : g_pad
            assign rsp.expired_mask[j] = 1'b0;
            assign rsp.notify_mask[j]  = 1'b0;
            assign rsp.running_mask[j] = 1'b0;
        end
    end

    `MCTT_ASSERT(a_notify_in_expired, !out_valid_reg || ((notify_reg & ~expired_reg) == '0), "notify set for timer that did not expire")
    `MCTT_ASSERT(a_expired_not_running, !out_valid_reg || ((expired_reg & running_reg) == '0), "expired timer still running")
    `MCTT_ASSERT(a_count_bounded, over_period == '0, "armed timer count above its period")
    `MCTT_ASSERT_NEXT(a_expire_only_on_check, proc && (req_type_reg != REQ_CHECK), expired_reg == '0, "expiry reported outside a check")
    `MCTT_ASSERT_NEXT(a_proc_gives_beat, proc, out_valid_reg, "processed request produced no response beat")

endmodule

>>> tb/mctt_checker.sv
// Checker for the timeout timer bank: predicts each response beat and compares it
module mctt_checker (
    input  logic clk,
    input  logic rst_n,
    mctt_req_if  req,
    mctt_rsp_if  rsp,
    output int   fail_count,
    output int   pending,
    output int   beats,
    output int   expirations,
    output int   notifications
);
    timeunit 1ns;
    timeprecision 1ps;
    import mctt_pkg::*;

    typedef struct packed {
        logic [MASK_W-1:0] expired;
        logic [MASK_W-1:0] notify;
        logic [MASK_W-1:0] running;
    } mask_set_t;

    logic                       armed        [NUM_TIMERS_DEF];
    logic [COUNT_WIDTH_DEF-1:0] tick_count   [NUM_TIMERS_DEF];
    logic [COUNT_WIDTH_DEF-1:0] period_value [NUM_TIMERS_DEF];
    logic                       handler_flag [NUM_TIMERS_DEF];

    mask_set_t expected_masks[$];

    function automatic mask_set_t timer_bank_step(
        input logic [REQ_W-1:0]    kind,
        input logic [ID_W-1:0]     id,
        input logic [PERIOD_W-1:0] period,
        input logic                handler
    );
        mask_set_t res;
        res = '0;
        case (kind)
            REQ_START:
            begin
                if (id < NUM_TIMERS_DEF && !armed[id])
                begin
                    tick_count[id]   = '0;
                    period_value[id] = COUNT_WIDTH_DEF'(period);
                    handler_flag[id] = handler;
                    armed[id]        = 1'b1;
                end
            end
            REQ_STOP:
            begin
                if (id < NUM_TIMERS_DEF && armed[id])
                begin
                    armed[id]      = 1'b0;
                    tick_count[id] = '0;
                end
            end
            REQ_TICK:
            begin
                for (int i = 0; i < NUM_TIMERS_DEF; i++)
                begin
                    if (armed[i] && tick_count[i] < period_value[i])
                        tick_count[i] = tick_count[i] + 1'b1;
                end
            end
            REQ_CHECK:
            begin
                for (int i = 0; i < NUM_TIMERS_DEF; i++)
                begin
                    if (armed[i] && tick_count[i] >= period_value[i])
                    begin
                        armed[i]          = 1'b0;
                        tick_count[i]     = '0;
                        res.expired[i]    = 1'b1;
                        res.notify[i]     = handler_flag[i];
                    end
                end
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < NUM_TIMERS_DEF; i++)
                begin
                    armed[i]        = 1'b0;
                    tick_count[i]   = '0;
                    handler_flag[i] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < NUM_TIMERS_DEF; i++)
            res.running[i] = armed[i];
        return res;
    endfunction

    task automatic compare_field(
        input string             name,
        input logic [MASK_W-1:0] want,
        input logic [MASK_W-1:0] got
    );
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        mask_set_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS_DEF; i++)
            begin
                armed[i]        = 1'b0;
                tick_count[i]   = '0;
                period_value[i] = '0;
                handler_flag[i] = 1'b0;
            end
            expected_masks.delete();
            fail_count    = 0;
            pending       = 0;
            beats         = 0;
            expirations   = 0;
            notifications = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                beats++;
                if (expected_masks.size() == 0)
                begin
                    $display("%0t: unexpected response beat, expected none, got %h %h %h",
                             $time, rsp.expired_mask, rsp.notify_mask, rsp.running_mask);
                    fail_count++;
                end
                else
                begin
                    want = expected_masks.pop_front();
                    compare_field("expired_mask", want.expired, rsp.expired_mask);
                    compare_field("notify_mask", want.notify, rsp.notify_mask);
                    compare_field("running_mask", want.running, rsp.running_mask);
                    expirations   += $countones(want.expired);
                    notifications += $countones(want.notify);
                end
            end
            if (req.valid && req.ready)
                expected_masks.push_back(timer_bank_step(req.req_type, req.timer_id,
                                                         req.period_ms, req.has_handler));
            pending = expected_masks.size();
        end
    end

endmodule

>>> tb/tb_multi_channel_timeout_timer_bank.sv
// Testbench top for the timeout timer bank: clock, reset, request and response traffic, verdict
module tb_multi_channel_timeout_timer_bank;
    timeunit 1ns;
    timeprecision 1ps;
    import mctt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 200;
    localparam int PHASE_COUNT  = 6;

    logic clk;
    logic rst_n;
    logic req_took;
    logic rsp_took;

    int fail_count;
    int pending;
    int beats;
    int expirations;
    int notifications;
    int gap_max;
    int stall_max;
    int long_stall;
    int cycles;

    mctt_req_if req_ch ();
    mctt_rsp_if rsp_ch ();

    multi_channel_timeout_timer_bank u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    mctt_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats         (beats),
        .expirations   (expirations),
        .notifications (notifications)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_took <= 1'b0;
            rsp_took <= 1'b0;
        end
        else
        begin
            req_took <= req_ch.valid && req_ch.ready;
            rsp_took <= rsp_ch.valid && rsp_ch.ready;
        end
    end

    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d beats outstanding", cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_beat(
        input logic [REQ_W-1:0]    kind,
        input logic [ID_W-1:0]     id,
        input logic [PERIOD_W-1:0] period,
        input logic                handler
    );
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.timer_id    <= id;
        req_ch.period_ms   <= period;
        req_ch.has_handler <= handler;
        do @(negedge clk); while (!req_took);
    endtask

    task automatic send_random_beat();
        int                  pick;
        logic [REQ_W-1:0]    kind;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        pick = $urandom_range(99, 0);
        if (pick < 25)
            kind = REQ_START;
        else if (pick < 35)
            kind = REQ_STOP;
        else if (pick < 70)
            kind = REQ_TICK;
        else if (pick < 92)
            kind = REQ_CHECK;
        else if (pick < 95)
            kind = REQ_CLEAR;
        else
            kind = REQ_W'($urandom_range(7, 5));
        if ($urandom_range(19, 0) == 0)
            id = ID_W'(NUM_TIMERS_DEF);
        else
            id = ID_W'($urandom_range(NUM_TIMERS_DEF - 1, 0));
        pick = $urandom_range(9, 0);
        if (pick < 7)
            period = PERIOD_W'($urandom_range(6, 0));
        else if (pick < 9)
            period = PERIOD_W'($urandom_range(40, 0));
        else
            period = PERIOD_W'($urandom());
        send_beat(kind, id, period, 1'($urandom_range(1, 0)));
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (long_stall > 0)
            begin
                n          = long_stall;
                long_stall = 0;
            end
            else
                n = $urandom_range(stall_max, 0);
            if (n > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(negedge clk); while (!rsp_took);
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_TICK;
        req_ch.timer_id    = '0;
        req_ch.period_ms   = '0;
        req_ch.has_handler = 1'b0;
        gap_max            = 13;
        stall_max          = 13;
        long_stall         = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_beat(REQ_TICK, 3'd0, 16'd0, 1'b0);
        send_beat(REQ_START, 3'd0, 16'd0, 1'b1);
        send_beat(REQ_CHECK, 3'd0, 16'd0, 1'b0);
        send_beat(REQ_START, 3'd6, 16'hFFFF, 1'b0);
        send_beat(REQ_START, 3'd6, 16'd1, 1'b1);
        send_beat(REQ_START, ID_W'(NUM_TIMERS_DEF), 16'd1, 1'b1);
        send_beat(REQ_STOP, ID_W'(NUM_TIMERS_DEF), 16'd0, 1'b0);
        send_beat(REQ_STOP, 3'd1, 16'd0, 1'b0);
        send_beat(REQ_START, 3'd1, 16'd2, 1'b1);
        send_beat(REQ_START, 3'd2, 16'd1, 1'b0);
        send_beat(REQ_CHECK, 3'd0, 16'd0, 1'b0);
        send_beat(REQ_TICK, 3'd7, 16'hFFFF, 1'b1);
        send_beat(REQ_TICK, 3'd0, 16'd0, 1'b0);
        send_beat(REQ_TICK, 3'd0, 16'd0, 1'b0);
        send_beat(REQ_CHECK, 3'd0, 16'd0, 1'b0);
        send_beat(REQ_STOP, 3'd6, 16'd0, 1'b0);
        send_beat(3'd5, 3'd0, 16'd0, 1'b0);
        send_beat(3'd6, 3'd0, 16'd0, 1'b0);
        send_beat(3'd7, 3'd0, 16'd0, 1'b0);
        send_beat(REQ_START, 3'd3, 16'd3, 1'b1);
        send_beat(REQ_START, 3'd4, 16'h8000, 1'b1);
        send_beat(REQ_CLEAR, 3'd0, 16'd0, 1'b0);
        send_beat(REQ_CHECK, 3'd0, 16'd0, 1'b0);
        send_beat(REQ_START, 3'd3, 16'd0, 1'b0);
        send_beat(REQ_CHECK, 3'd0, 16'd0, 1'b0);
        drain_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: begin gap_max = 13; stall_max = 13; end
                1: begin gap_max = 0;  stall_max = 0;  long_stall = 120; end
                2: begin gap_max = 0;  stall_max = 13; end
                3: begin gap_max = 13; stall_max = 0;  drain_results(); end
                4: begin gap_max = 3;  stall_max = 3;  end
                default: begin gap_max = 13; stall_max = 13; end
            endcase
            repeat (PHASE_ITEMS) send_random_beat();
        end

        drain_results();
        repeat (8) @(negedge clk);
        $display("Covered %0d request/response beats in %0d cycles: all request kinds,",
                 beats, cycles);
        $display("%0d timer expirations (%0d notified), long response stall and a full drain.",
                 expirations, notifications);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
